/* design/assert_macros.svh */
// assertion macros used by the rtl of the sorted wakeup timer queue
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

/* design/swtq_pkg.sv */
// types and constants for the sorted wakeup timer queue
// no dependencies; used by sorted_wakeup_timer_queue
`default_nettype none

package swtq_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int MAX_WAKE         = 16;
   localparam int TIME_W           = 63;
   localparam int ID_W             = 8;

   // request operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_PAST     = 3'd1,
      ST_FULL     = 3'd2,
      ST_WOKEN    = 3'd3,
      ST_IDLE     = 3'd4
   } status_type;

   typedef struct packed {
      logic              operation;
      logic [ID_W-1:0]   thread_id;
      logic [TIME_W-1:0] alarm_tick;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   woken_thread;
      logic [TIME_W-1:0] current_tick;
      logic              last;
   } rsp_type;

   // one sleeper as held in the list memory
   typedef struct packed {
      logic [TIME_W-1:0] wake_time;
      logic [ID_W-1:0]   id;
   } entry_type;

endpackage

`default_nettype wire

/* design/sorted_wakeup_timer_queue.sv */
// sorted wakeup timer queue: tick counter plus a time-sorted sleeper list in one memory
// depends on swtq_pkg and assert_macros.svh
`default_nettype none
//
// Usage. A request beat is taken when start is high and busy is low. An insert
// (operation 0) places thread_id at alarm_tick in the sorted list, ahead of
// sleepers with the same time; a time at or before the current tick answers
// "past", a full list answers "full". A tick (operation 1) advances the counter
// and pops every head sleeper due at the new tick, at most 16, one result beat
// each with last on the final one, or a single "nothing due" beat.
// Results come out on rsp_valid/rsp_data for one cycle each; the receiver
// cannot stall, so every result is delivered at one beat per cycle.
// Timing: a rejected insert, or an insert into an empty list, answers the next
// cycle and busy stays low; any other insert shifts the entries at or after its
// place up one per cycle by the read-modify-write loop over the single list
// memory, then writes the new sleeper into the gap and answers.
// A tick reads the head unless the list is empty, and pops the woken sleepers
// with one memory read per pop.
// Reset empties the list and clears the tick counter at once; the memory
// contents need no clearing pass, since only filled entries are ever read.
//
module sorted_wakeup_timer_queue #(
   parameter int CAPACITY = swtq_pkg::DEFAULT_CAPACITY
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  swtq_pkg::req_type req_data,
   output logic             rsp_valid,
   output swtq_pkg::rsp_type rsp_data
);
   import swtq_pkg::*;

   `include "assert_macros.svh"

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int NW = $clog2(MAX_WAKE + 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_ISHIFT = 6'b000010,
      S_IPLACE = 6'b000100,
      S_TSTART = 6'b001000,
      S_TCHECK = 6'b010000,
      S_TFLUSH = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [TIME_W-1:0] tick_ff, tick_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic [TIME_W-1:0] new_time_ff, new_time_in;
   logic [ID_W-1:0]   new_id_ff, new_id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // list memory, one read and one write port
   entry_type         mem [CAPACITY];
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   entry_type         rd_data_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_data;
   entry_type         new_entry;

   // logical list position to physical address in the circular memory
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [CW-1:0] ofs);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW+1)'(ofs);
      if (sum >= (AW+1)'(CAPACITY)) begin
         sum = sum - (AW+1)'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign new_entry = '{wake_time: new_time_ff, id: new_id_ff};

   // sequencer: insert walks from the tail shifting entries up, tick pops the head
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      tick_in       = tick_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      new_time_in   = new_time_ff;
      new_id_in     = new_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_data       = new_entry;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.operation == OP_INSERT) begin
                  new_time_in = req_data.alarm_tick;
                  new_id_in   = req_data.thread_id;
                  rsp_in      = '{status: ST_INSERTED, woken_thread: '0,
                                  current_tick: tick_ff, last: 1'b1};
                  priority if (req_data.alarm_tick <= tick_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_PAST;
                  end else if (count_ff == CW'(CAPACITY)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_FULL;
                  end else if (count_ff == '0) begin
                     wr_en        = 1'b1;
                     wr_addr      = head_ff;
                     wr_data      = '{wake_time: req_data.alarm_tick,
                                      id: req_data.thread_id};
                     count_in     = count_ff + CW'(1);
                     rsp_valid_in = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = phys(head_ff, count_ff - CW'(1));
                     idx_in   = count_ff;
                     state_in = S_ISHIFT;
                  end
               end else begin
                  tick_in       = tick_ff + TIME_W'(1);
                  n_in          = '0;
                  pend_valid_in = 1'b0;
                  state_in      = S_TSTART;
               end
            end
         end

         // rd_data_ff holds the entry just below idx
         S_ISHIFT: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, idx_ff);
            if (new_time_ff > rd_data_ff.wake_time) begin
               wr_data      = new_entry;
               count_in     = count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_INSERTED, woken_thread: '0,
                                current_tick: tick_ff, last: 1'b1};
               state_in     = S_IDLE;
            end else begin
               wr_data = rd_data_ff;
               idx_in  = idx_ff - CW'(1);
               if (idx_ff == CW'(1)) begin
                  state_in = S_IPLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = phys(head_ff, idx_ff - CW'(2));
               end
            end
         end

         // new sleeper goes to the head
         S_IPLACE: begin
            wr_en        = 1'b1;
            wr_addr      = head_ff;
            wr_data      = new_entry;
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_INSERTED, woken_thread: '0,
                             current_tick: tick_ff, last: 1'b1};
            state_in     = S_IDLE;
         end

         S_TSTART: begin
            if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_IDLE, woken_thread: '0,
                                current_tick: tick_ff, last: 1'b1};
               state_in     = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = S_TCHECK;
            end
         end

         // a woken id is held in pend_id_ff until the next head check or the flush state, so its last flag is known
         S_TCHECK: begin
            if (rd_data_ff.wake_time == tick_ff) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_WOKEN, woken_thread: pend_id_ff,
                                   current_tick: tick_ff, last: 1'b0};
               end
               pend_valid_in = 1'b1;
               pend_id_in    = rd_data_ff.id;
               head_in       = phys(head_ff, CW'(1));
               count_in      = count_ff - CW'(1);
               n_in          = n_ff + NW'(1);
               if ((count_ff != CW'(1)) && ((32'(n_ff) + 1) < MAX_WAKE)) begin
                  rd_en   = 1'b1;
                  rd_addr = phys(head_ff, CW'(1));
               end else begin
                  state_in = S_TFLUSH;
               end
            end else begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in = '{status: ST_WOKEN, woken_thread: pend_id_ff,
                             current_tick: tick_ff, last: 1'b1};
               end else begin
                  rsp_in = '{status: ST_IDLE, woken_thread: '0,
                             current_tick: tick_ff, last: 1'b1};
               end
               state_in = S_IDLE;
            end
         end

         S_TFLUSH: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_WOKEN, woken_thread: pend_id_ff,
                             current_tick: tick_ff, last: 1'b1};
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         n_ff          <= '0;
         tick_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         n_ff          <= n_in;
         tick_ff       <= tick_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_id_ff  <= pend_id_in;
      new_time_ff <= new_time_in;
      new_id_ff   <= new_id_in;
      rsp_ff      <= rsp_in;
   end

   // list memory access
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `ASSERT_IMPLIES(a_shift_idx, clock, reset, state_ff == S_ISHIFT, idx_ff != '0)
   `ASSERT_NEXT(a_accept_acts, clock, reset, start && !busy, busy || rsp_valid)
   `ASSERT_NEXT(a_tick_step, clock, reset, start && !busy && req_data.operation == OP_TICK,
      tick_ff == $past(tick_ff) + TIME_W'(1))

endmodule

`default_nettype wire

/* tb/tb_sorted_wakeup_timer_queue.sv */
// self-checking testbench for the sorted wakeup timer queue: directed and random
// insert/tick beats checked against a shadow sleeper list; depends on swtq_pkg
module tb_sorted_wakeup_timer_queue;
   import swtq_pkg::*;

   localparam int CAPACITY    = DEFAULT_CAPACITY;
   localparam int RANDOM_BEATS = 280;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;

   sorted_wakeup_timer_queue #(.CAPACITY(CAPACITY)) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // 10 unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the timer state
   entry_type sleeper_list[$];
   logic [TIME_W-1:0] tick_now = '0;

   // request beats waiting to go out and result beats still owed by the block
   req_type request_backlog[$];
   rsp_type owed_results[$];

   int n_queued = 0;
   int n_taken = 0;
   int gap_left = 0;
   int mismatch_count = 0;
   bit gaps_on = 1'b1;
   rsp_type want;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // advance the shadow list by one request beat and queue the owed results
   function automatic void apply_timer_request(input req_type r);
      entry_type e;
      rsp_type o;
      int pos;
      int woke;
      o = '0;
      if (r.operation == OP_INSERT) begin
         o.last = 1'b1;
         o.current_tick = tick_now;
         if (r.alarm_tick <= tick_now) begin
            o.status = ST_PAST;
         end else if (sleeper_list.size() >= CAPACITY) begin
            o.status = ST_FULL;
         end else begin
            // equal times go ahead of the sleepers already there
            pos = 0;
            while (pos < sleeper_list.size() && r.alarm_tick > sleeper_list[pos].wake_time)
               pos++;
            e.wake_time = r.alarm_tick;
            e.id = r.thread_id;
            sleeper_list.insert(pos, e);
            o.status = ST_INSERTED;
         end
         owed_results.push_back(o);
      end else begin
         tick_now = tick_now + 1'b1;
         woke = 0;
         while (woke < MAX_WAKE && sleeper_list.size() > 0
                && sleeper_list[0].wake_time == tick_now) begin
            o.status = ST_WOKEN;
            o.woken_thread = sleeper_list[0].id;
            o.current_tick = tick_now;
            o.last = 1'b0;
            void'(sleeper_list.pop_front());
            owed_results.push_back(o);
            woke++;
         end
         if (woke == 0) begin
            o.status = ST_IDLE;
            o.current_tick = tick_now;
            o.last = 1'b1;
            owed_results.push_back(o);
         end else begin
            owed_results[$].last = 1'b1;
         end
      end
   endfunction

   // request driver: holds a beat until taken, then maybe idles for a burst
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            apply_timer_request(req_data);
            n_taken++;
            if (gaps_on && $urandom_range(0, 2) == 0)
               gap_left = $urandom_range(1, 6);
         end
         if (start && busy) begin
            // beat still waiting
         end else if (gap_left > 0 || request_backlog.size() == 0) begin
            start <= 1'b0;
            if (gap_left > 0)
               gap_left--;
         end else begin
            start <= 1'b1;
            req_data <= request_backlog.pop_front();
         end
      end
   end

   // result monitor: every strobed beat must match the oldest owed result
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (owed_results.size() == 0) begin
            report_mismatch("result beat with nothing owed");
         end else begin
            want = owed_results.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, wanted %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.woken_thread !== want.woken_thread)
               report_mismatch($sformatf("woken_thread %0d, wanted %0d",
                                         rsp_data.woken_thread, want.woken_thread));
            if (rsp_data.current_tick !== want.current_tick)
               report_mismatch($sformatf("current_tick %0d, wanted %0d",
                                         rsp_data.current_tick, want.current_tick));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %0b, wanted %0b",
                                         rsp_data.last, want.last));
         end
      end
   end

   task automatic queue_insert(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t);
      req_type r;
      r.operation = OP_INSERT;
      r.thread_id = id;
      r.alarm_tick = t;
      request_backlog.push_back(r);
      n_queued++;
   endtask

   task automatic queue_tick();
      req_type r;
      r.operation = OP_TICK;
      r.thread_id = ID_W'($urandom);
      r.alarm_tick = TIME_W'($urandom);
      request_backlog.push_back(r);
      n_queued++;
   endtask

   // stimulus: directed beats, then random episodes built on the shadow state
   initial begin : stimulus
      logic [TIME_W-1:0] now;
      logic [63:0] r64;
      int occ;
      int n_directed;
      int kind;
      int span;
      int k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty tick, past and present times, equal-time ordering
      queue_tick();
      queue_insert(8'h00, '0);
      queue_insert(8'hFF, 63'd1);
      queue_insert(8'hFF, 63'd3);
      queue_insert(8'h00, 63'd3);
      queue_insert(8'h5A, 63'd2);
      queue_tick();
      queue_tick();
      // full list, past check ahead of full check, then a sixteen-sleeper wake
      for (int i = 0; i < CAPACITY; i++)
         queue_insert(ID_W'(i * 17), 63'd5);
      queue_insert(8'hC3, {TIME_W{1'b1}});
      queue_insert(8'h3C, 63'd3);
      queue_tick();
      queue_tick();
      // one sleeper at the latest time stays for the whole run
      queue_insert(8'hA5, {TIME_W{1'b1}});
      n_directed = n_queued;

      // sender holds off until the block has answered everything
      wait (n_taken == n_queued);
      wait (owed_results.size() == 0);

      while (n_queued - n_directed < RANDOM_BEATS) begin
         wait (n_taken == n_queued);
         now = tick_now;
         occ = sleeper_list.size();
         gaps_on = ($urandom_range(0, 3) != 0) && (n_queued - n_directed < RANDOM_BEATS - 50);
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            // batch of sleepers due soon, then enough ticks to wake them all
            span = $urandom_range(1, 6);
            k = (occ < CAPACITY) ? $urandom_range(1, CAPACITY - occ) : 0;
            for (int i = 0; i < k; i++) begin
               if ($urandom_range(0, 7) == 0)
                  queue_insert(ID_W'($urandom), TIME_W'($urandom) % (now + 1'b1));
               queue_insert(ID_W'($urandom), now + TIME_W'($urandom_range(1, span)));
            end
            for (int i = 0; i < span + $urandom_range(0, 1); i++)
               queue_tick();
         end else if (kind <= 7) begin
            // fill the list, overflow it with wide random times, then drain
            span = $urandom_range(1, 3);
            for (int i = occ; i < CAPACITY; i++)
               queue_insert(ID_W'($urandom), now + TIME_W'($urandom_range(1, span)));
            for (int i = 0; i < $urandom_range(1, 3); i++) begin
               r64 = {$urandom, $urandom};
               queue_insert(ID_W'($urandom), r64[TIME_W-1:0]);
            end
            if ($urandom_range(0, 1) == 0)
               queue_insert(ID_W'($urandom), TIME_W'($urandom) % (now + 1'b1));
            for (int i = 0; i < span; i++)
               queue_tick();
         end else if (kind == 8) begin
            // noise: idle ticks and late inserts
            for (int i = 0; i < $urandom_range(1, 4); i++) begin
               if ($urandom_range(0, 1) == 0)
                  queue_tick();
               else
                  queue_insert(ID_W'($urandom), TIME_W'($urandom) % (now + 1'b1));
            end
         end else begin
            wait (owed_results.size() == 0);
         end
      end
      gaps_on = 1'b0;

      // drain and let the block settle
      wait (n_taken == n_queued);
      wait (owed_results.size() == 0);
      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
